// File: rtl/core/ple_pkg.sv
package ple_pkg;

   // Default number of entries the list can hold
   localparam int PLE_CAPACITY = 64;

   // Fixed field widths of the request and response transactions
   localparam int PLE_CMD_W = 2;
   localparam int PLE_POS_W = 7;
   localparam int PLE_VAL_W = 8;

   // Request command codes
   localparam logic [PLE_CMD_W-1:0] PLE_CMD_INSERT = 2'd0;
   localparam logic [PLE_CMD_W-1:0] PLE_CMD_DELETE = 2'd1;
   localparam logic [PLE_CMD_W-1:0] PLE_CMD_GET    = 2'd2;
   localparam logic [PLE_CMD_W-1:0] PLE_CMD_LOCATE = 2'd3;

   // Broadcast shift control seen by every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } ple_ctrl_type;

endpackage

// File: rtl/core/ple_req_if.sv
interface ple_req_if import ple_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PLE_CMD_W-1:0] command;
   logic [PLE_POS_W-1:0] position;
   logic [PLE_VAL_W-1:0] value;

   modport source (output valid, output command, output position, output value, input ready);
   modport sink   (input valid, input command, input position, input value, output ready);
endinterface

// File: rtl/core/ple_rsp_if.sv
interface ple_rsp_if import ple_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 ok;
   logic [PLE_VAL_W-1:0] read_value;
   logic [PLE_POS_W-1:0] found_at;
   logic [PLE_POS_W-1:0] length;

   modport source (output valid, output ok, output read_value, output found_at,
                   output length, input ready);
   modport sink   (input valid, input ok, input read_value, input found_at,
                   input length, output ready);
endinterface

// File: rtl/core/ple_cell.sv
module ple_cell import ple_pkg::*; #(
   parameter int CAPACITY = PLE_CAPACITY,
   parameter int INDEX    = 0,
   localparam int IW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                 clock,
   input  ple_ctrl_type         ctrl,
   input  logic [IW-1:0]        target,
   input  logic [CW-1:0]        count,
   input  logic [PLE_VAL_W-1:0] left_entry,
   input  logic [PLE_VAL_W-1:0] right_entry,
   input  logic [PLE_VAL_W-1:0] new_value,
   output logic [PLE_VAL_W-1:0] entry,
   output logic                 match,
   output logic [PLE_VAL_W-1:0] read_data
);

   localparam logic [IW-1:0] MY_SLOT  = IW'(INDEX);
   localparam logic [CW-1:0] MY_COUNT = CW'(INDEX);

   logic [PLE_VAL_W-1:0] entry_ff;
   logic [PLE_VAL_W-1:0] entry_in;

   // Take the new value, shift back from the left, close up from the right, or hold
   always_comb begin
      priority if (ctrl.insert && (MY_SLOT == target)) begin
         entry_in = new_value;
      end else if (ctrl.insert && (MY_SLOT > target)) begin
         entry_in = left_entry;
      end else if (ctrl.remove && (MY_SLOT >= target)) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Compare and read taps; only occupied cells may match
   assign entry     = entry_ff;
   assign match     = (MY_COUNT < count) && (entry_ff == new_value);
   assign read_data = (MY_SLOT == target) ? entry_ff : '0;

endmodule

// File: rtl/core/ple_first_match.sv
module ple_first_match import ple_pkg::*; #(
   parameter int CAPACITY = PLE_CAPACITY,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic [CAPACITY-1:0] match,
   output logic [CW-1:0]       found
);

   logic [CAPACITY-1:0] first;

   // Isolate the lowest set bit, then encode it as a 1-based position
   assign first = match & (~match + CAPACITY'(1));

   always_comb begin
      found = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         found = found | (first[k] ? CW'(k + 1) : '0);
      end
   end

endmodule

// File: rtl/core/positional_list_engine.sv
// Positional list engine: an ordered list of byte entries held in a row of
// cells, each cell one entry, shifting with its neighbours.
// Request channel (req_chan) carries command, 1-based position and value;
// commands are insert, delete, get by position and locate by value.
// Response channel (rsp_chan) returns ok, read_value, found_at and the
// list length after the operation, one response per request.
// Latency: a response is valid in the cycle after its request is taken.
// Throughput: one transaction per cycle; every cell shifts and compares in
// the same cycle, and the first-match encoder over all cells sets the path.
// The response register frees as it is taken, so requests keep flowing
// while the receiver takes each response.
// Stall: when a response waits untaken, req_chan.ready drops until it goes.
// Reset (synchronous, active high) empties the list, drops rsp valid and
// holds req_chan.ready low; entry contents are not cleared and are never
// read before being written.
// A bad position or an insert into a full list returns ok low and leaves
// the list unchanged; locate always returns ok high.
module positional_list_engine import ple_pkg::*; #(
   parameter int CAPACITY = PLE_CAPACITY
) (
   input  logic     clock,
   input  logic     reset,
   ple_req_if.sink  req_chan,
   ple_rsp_if.source rsp_chan
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > PLE_POS_W) ? CW : PLE_POS_W;
   localparam logic [CW-1:0] FULL = CW'(CAPACITY);

   logic [CW-1:0]        count_ff, count_in;
   logic                 rsp_valid_ff;
   logic                 ok_ff, ok_in;
   logic [PLE_VAL_W-1:0] read_ff, read_in;
   logic [PLE_POS_W-1:0] found_ff, found_in;

   logic                 accept;
   logic [PW-1:0]        pos_ext, cnt_ext;
   logic                 pos_ok, ins_ok;
   logic [IW-1:0]        target;
   ple_ctrl_type         ctrl;

   logic [PLE_VAL_W-1:0] entries [CAPACITY];
   logic [PLE_VAL_W-1:0] reads   [CAPACITY];
   logic [CAPACITY-1:0]  match;
   logic [PLE_VAL_W-1:0] read_any;
   logic [CW-1:0]        found;

   // Handshake: out of reset, take a request whenever the response slot is free or leaving
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   // Position checks
   assign pos_ext = PW'(req_chan.position);
   assign cnt_ext = PW'(count_ff);
   assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
   assign ins_ok  = (pos_ext != '0) && ((pos_ext - PW'(1)) <= cnt_ext) && (count_ff != FULL);
   assign target  = IW'(pos_ext - PW'(1));

   assign ctrl.insert = accept && (req_chan.command == PLE_CMD_INSERT) && ins_ok;
   assign ctrl.remove = accept && (req_chan.command == PLE_CMD_DELETE) && pos_ok;

   // Row of cells
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [PLE_VAL_W-1:0] left_entry;
      logic [PLE_VAL_W-1:0] right_entry;

      if (k == 0) begin : g_head
         assign left_entry = entries[k];
      end else begin : g_body_l
         assign left_entry = entries[k-1];
      end
      if (k == CAPACITY - 1) begin : g_tail
         assign right_entry = entries[k];
      end else begin : g_body_r
         assign right_entry = entries[k+1];
      end

      ple_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (k)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .target      (target),
         .count       (count_ff),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .new_value   (req_chan.value),
         .entry       (entries[k]),
         .match       (match[k]),
         .read_data   (reads[k])
      );
   end

   // Gather the addressed entry
   always_comb begin
      read_any = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         read_any = read_any | reads[k];
      end
   end

   ple_first_match #(
      .CAPACITY (CAPACITY)
   ) u_first_match (
      .match (match),
      .found (found)
   );

   // Result and length update
   always_comb begin
      count_in = count_ff;
      ok_in    = 1'b0;
      read_in  = '0;
      found_in = '0;
      unique case (req_chan.command)
         PLE_CMD_INSERT: begin
            ok_in = ins_ok;
            if (ctrl.insert) count_in = count_ff + CW'(1);
         end
         PLE_CMD_DELETE: begin
            ok_in = pos_ok;
            if (ctrl.remove) count_in = count_ff - CW'(1);
         end
         PLE_CMD_GET: begin
            ok_in   = pos_ok;
            read_in = pos_ok ? read_any : '0;
         end
         PLE_CMD_LOCATE: begin
            ok_in    = 1'b1;
            found_in = PLE_POS_W'(found);
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff    <= ok_in;
         read_ff  <= read_in;
         found_ff <= found_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ok         = ok_ff;
   assign rsp_chan.read_value = read_ff;
   assign rsp_chan.found_at   = found_ff;
   assign rsp_chan.length     = PLE_POS_W'(count_ff);

endmodule

// File: dv/positional_list_engine_tb.sv
`timescale 1ns / 1ps

module positional_list_engine_tb;
   import ple_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1400;
   localparam int TAIL_CYCLES = 10;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [PLE_CMD_W-1:0] command;
      logic [PLE_POS_W-1:0] position;
      logic [PLE_VAL_W-1:0] value;
   } list_request_type;

   typedef struct packed {
      logic                 ok;
      logic [PLE_VAL_W-1:0] read_value;
      logic [PLE_POS_W-1:0] found_at;
      logic [PLE_POS_W-1:0] length;
   } list_result_type;

   typedef enum {PHASE_GROW, PHASE_SHRINK, PHASE_MIX} phase_kind_type;

   logic clock;
   logic reset;

   ple_req_if req_bus ();
   ple_rsp_if rsp_bus ();

   positional_list_engine dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the list, updated as each request is taken
   logic [PLE_VAL_W-1:0] shadow_entries [PLE_CAPACITY];
   int                   shadow_count;

   list_request_type pending_requests [$];
   list_result_type  due_results [$];

   int req_sent;
   int req_accepted;
   int send_gap;
   bit send_steady;
   int recv_stall;
   int recv_seen;
   int rsp_accepted;
   bit recv_steady;
   int cycle_count;
   int fault_count;
   int gen_length;

   list_request_type send_item;
   list_request_type taken_item;
   list_result_type  got_result;
   list_result_type  exp_result;

   // Apply one request to the shadow list and return the response it should give
   function automatic list_result_type apply_request(list_request_type rq);
      list_result_type r;
      int              p;
      int              k;
      r = '0;
      p = int'(rq.position);
      case (rq.command)
         PLE_CMD_INSERT: begin
            if (p >= 1 && p <= shadow_count + 1 && shadow_count < PLE_CAPACITY) begin
               for (k = shadow_count; k > p - 1; k--)
                  shadow_entries[k] = shadow_entries[k - 1];
               shadow_entries[p - 1] = rq.value;
               shadow_count++;
               r.ok = 1'b1;
            end
         end
         PLE_CMD_DELETE: begin
            if (p >= 1 && p <= shadow_count) begin
               for (k = p - 1; k + 1 < shadow_count; k++)
                  shadow_entries[k] = shadow_entries[k + 1];
               shadow_count--;
               r.ok = 1'b1;
            end
         end
         PLE_CMD_GET: begin
            if (p >= 1 && p <= shadow_count) begin
               r.read_value = shadow_entries[p - 1];
               r.ok = 1'b1;
            end
         end
         PLE_CMD_LOCATE: begin
            r.ok = 1'b1;
            for (k = 0; k < shadow_count; k++)
               if (r.found_at == 0 && shadow_entries[k] == rq.value)
                  r.found_at = PLE_POS_W'(k + 1);
         end
         default: ;
      endcase
      r.length = PLE_POS_W'(shadow_count);
      return r;
   endfunction

   // Queue a request; keep a running length so positions can be aimed
   task automatic queue_request(logic [PLE_CMD_W-1:0] cmd, int pos, int val);
      list_request_type rq;
      rq.command = cmd;
      rq.position = PLE_POS_W'(pos);
      rq.value = PLE_VAL_W'(val);
      pending_requests.push_back(rq);
      if (cmd == PLE_CMD_INSERT && pos >= 1 && pos <= gen_length + 1
          && gen_length < PLE_CAPACITY)
         gen_length++;
      else if (cmd == PLE_CMD_DELETE && pos >= 1 && pos <= gen_length)
         gen_length--;
   endtask

   function automatic int draw_pause(bit steady);
      return steady ? 0 : $urandom_range(0, 4);
   endfunction

   // Small alphabet most of the time so that locates hit and duplicates occur
   function automatic int pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return $urandom_range(0, 7);
      if (r < 55)
         return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return $urandom_range(0, 255);
   endfunction

   // Mostly in range; now and then anywhere the field allows
   function automatic int pick_position(int top);
      if ($urandom_range(0, 99) < 12 || top < 1)
         return $urandom_range(0, 127);
      return $urandom_range(1, top);
   endfunction

   // Clock, reset and known input levels
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = PLE_CMD_LOCATE;
      req_bus.position = '0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Request driver: one transaction held until taken, random gaps between
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && req_accepted != req_sent) begin
         // waiting for the engine to take it
      end else if (send_gap > 0) begin
         req_bus.valid <= 1'b0;
         send_gap--;
      end else if (pending_requests.size() != 0) begin
         send_item = pending_requests.pop_front();
         req_bus.valid <= 1'b1;
         req_bus.command <= send_item.command;
         req_bus.position <= send_item.position;
         req_bus.value <= send_item.value;
         req_sent++;
         if ($urandom_range(0, 99) < 3)
            send_steady = !send_steady;
         send_gap = draw_pause(send_steady);
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // Response receiver: after each transaction, stall for a random spell
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_accepted != recv_seen) begin
            recv_seen = rsp_accepted;
            if ($urandom_range(0, 99) < 3)
               recv_steady = !recv_steady;
            recv_stall = draw_pause(recv_steady);
         end
         if (recv_stall > 0) begin
            rsp_bus.ready <= 1'b0;
            recv_stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor: check responses first, then predict for the request taken this edge
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("positional_list_engine_tb: done, errors");
         $finish;
      end else if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_accepted++;
            got_result.ok = rsp_bus.ok;
            got_result.read_value = rsp_bus.read_value;
            got_result.found_at = rsp_bus.found_at;
            got_result.length = rsp_bus.length;
            if (due_results.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("%0t: response with nothing outstanding: %p", $realtime, got_result);
            end else begin
               exp_result = due_results.pop_front();
               if (got_result.ok !== exp_result.ok
                   || got_result.read_value !== exp_result.read_value
                   || got_result.found_at !== exp_result.found_at
                   || got_result.length !== exp_result.length) begin
                  fault_count++;
                  if (fault_count <= MAX_REPORTS)
                     $display("%0t: mismatch ok %b/%b read %h/%h found %0d/%0d len %0d/%0d",
                              $realtime, exp_result.ok, got_result.ok,
                              exp_result.read_value, got_result.read_value,
                              exp_result.found_at, got_result.found_at,
                              exp_result.length, got_result.length);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            req_accepted++;
            taken_item.command = req_bus.command;
            taken_item.position = req_bus.position;
            taken_item.value = req_bus.value;
            due_results.push_back(apply_request(taken_item));
         end
      end
   end

   // Stimulus and end of run
   initial begin
      phase_kind_type phase;
      int             phase_left;
      int             made;
      int             r;
      int             top;

      shadow_count = 0;
      gen_length = 0;
      foreach (shadow_entries[i])
         shadow_entries[i] = '0;

      // Directed: empty list, bad positions, ends and middle, duplicates
      queue_request(PLE_CMD_LOCATE, 0, 8'h00);
      queue_request(PLE_CMD_GET, 1, 8'h00);
      queue_request(PLE_CMD_DELETE, 1, 8'h00);
      queue_request(PLE_CMD_INSERT, 0, 8'h11);
      queue_request(PLE_CMD_INSERT, 2, 8'h22);
      queue_request(PLE_CMD_INSERT, 1, 8'h00);
      queue_request(PLE_CMD_INSERT, 2, 8'hFF);
      queue_request(PLE_CMD_INSERT, 1, 8'hA5);
      queue_request(PLE_CMD_INSERT, 3, 8'h5A);
      queue_request(PLE_CMD_GET, 1, 8'hFF);
      queue_request(PLE_CMD_GET, 4, 8'h00);
      queue_request(PLE_CMD_GET, 5, 8'h00);
      queue_request(PLE_CMD_GET, 0, 8'h00);
      queue_request(PLE_CMD_GET, 127, 8'h00);
      queue_request(PLE_CMD_LOCATE, 127, 8'hFF);
      queue_request(PLE_CMD_LOCATE, 0, 8'h5A);
      queue_request(PLE_CMD_INSERT, 2, 8'hFF);
      queue_request(PLE_CMD_LOCATE, 64, 8'hFF);
      queue_request(PLE_CMD_LOCATE, 0, 8'h7E);
      queue_request(PLE_CMD_DELETE, 0, 8'h00);
      queue_request(PLE_CMD_DELETE, 6, 8'h00);
      queue_request(PLE_CMD_DELETE, 5, 8'h00);
      queue_request(PLE_CMD_DELETE, 1, 8'h00);
      queue_request(PLE_CMD_DELETE, 2, 8'hFF);
      queue_request(PLE_CMD_GET, 2, 8'h00);

      // Random: phases that fill to capacity, drain to empty, or wander
      made = 0;
      phase_left = 0;
      phase = PHASE_MIX;
      while (made < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            r = $urandom_range(0, 2);
            phase = (r == 0) ? PHASE_GROW : (r == 1) ? PHASE_SHRINK : PHASE_MIX;
            phase_left = $urandom_range(40, 120);
         end
         r = $urandom_range(0, 99);
         case (phase)
            PHASE_GROW:   r = (r < 70) ? 0 : (r < 78) ? 1 : (r < 89) ? 2 : 3;
            PHASE_SHRINK: r = (r < 10) ? 0 : (r < 70) ? 1 : (r < 85) ? 2 : 3;
            default:      r = (r < 30) ? 0 : (r < 55) ? 1 : (r < 78) ? 2 : 3;
         endcase
         top = gen_length;
         case (r)
            0: queue_request(PLE_CMD_INSERT, pick_position(top + 1), pick_value());
            1: queue_request(PLE_CMD_DELETE, pick_position(top), $urandom_range(0, 255));
            2: queue_request(PLE_CMD_GET, pick_position(top), $urandom_range(0, 255));
            default: queue_request(PLE_CMD_LOCATE, $urandom_range(0, 127), pick_value());
         endcase
         made++;
         phase_left--;
      end

      // Drain, then let the pipeline settle
      while (pending_requests.size() != 0 || req_accepted != req_sent
             || due_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      fault_count += due_results.size();
      if (fault_count == 0)
         $display("positional_list_engine_tb: done, clean");
      else
         $display("positional_list_engine_tb: done, errors");
      $finish;
   end

endmodule

// File: positional_list_engine.f
rtl/core/ple_pkg.sv
rtl/core/ple_req_if.sv
rtl/core/ple_rsp_if.sv
rtl/core/ple_cell.sv
rtl/core/ple_first_match.sv
rtl/core/positional_list_engine.sv
dv/positional_list_engine_tb.sv
